FILE: sv/indexed_min_heap_decrease_key_assert.svh
// Assertion helpers, clocked on clock, held off during reset.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define IMH_ASSERT_SAME(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define IMH_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) else $error(msg);

`endif

FILE: sv/imhdk_pkg.sv
`default_nettype none
package imhdk_pkg;

   localparam int VTX_W        = 10;
   localparam int VERTEX_SLOTS = 1024;
   localparam int KEY_IN_W     = 32;
   localparam int KEY_EXT_W    = 48;
   localparam int CAPACITY_DEF = 1024;
   localparam int KEY_W_DEF    = 32;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      OP_UPDATE  = 1'b0,
      OP_EXTRACT = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POS,
      ST_UP_RD,
      ST_UP_CMP,
      ST_X_ROOT,
      ST_X_LAST,
      ST_DN_RD,
      ST_DN_L,
      ST_DN_R,
      ST_FIN
   } state_type;

endpackage
`default_nettype wire

FILE: sv/imhdk_ram.sv
`default_nettype none
module imhdk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: sv/indexed_min_heap_decrease_key.sv
// Indexed binary min-heap (priority queue for shortest-path search). A transaction
// with operation 0 inserts a vertex with a key, or overwrites the key of a vertex
// already held and sifts it upward only; operation 1 removes the smallest entry
// and returns its vertex. Status 1 flags an extract on an empty heap, status 2 an
// insert into a full heap. Heap slots and the per-vertex position table live in
// two single-port-read RAMs with a registered read. After reset the block stalls
// while it clears the position table. One transaction is worked at a time: an
// update reads the vertex's position, then per level it rises reads the parent
// and compares; an extract reads the root and the last entry, then per level it
// sinks reads the left and the right child and compares; either ends in a state
// that hands over the response. An extract on an empty heap goes straight to that
// state, an insert into a full heap after the position read. The walk over the
// heap levels, with its RAM reads and compares, sets how long a transaction takes.
// The response sits in an output register, so the next request is taken and
// worked while a response waits; it holds in its final state until the register frees.
`default_nettype none
`include "indexed_min_heap_decrease_key_assert.svh"
module indexed_min_heap_decrease_key
   import imhdk_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_W_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_operation,
   input  wire logic [VTX_W-1:0]    req_vertex,
   input  wire logic [KEY_IN_W-1:0] req_key,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [VTX_W-1:0]         rsp_vertex_out,
   output logic [1:0]               rsp_status
);

   localparam int SW  = $clog2(CAPACITY);       // slot index width
   localparam int CW  = $clog2(CAPACITY + 1);   // entry count width
   localparam int CXW = SW + 2;                 // child index width
   localparam int HW  = VTX_W + KEY_WIDTH;      // heap entry
   localparam int PW  = SW + 1;                 // present bit + slot

   state_type state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [SW-1:0]        s_ff, s_in;            // hole position
   logic [SW-1:0]        up_ff, up_in;
   logic [VTX_W-1:0]     e_vtx_ff, e_vtx_in;    // entry being sifted
   logic [KEY_WIDTH-1:0] e_key_ff, e_key_in;
   logic [VTX_W-1:0]     ch_vtx_ff, ch_vtx_in;  // left child
   logic [KEY_WIDTH-1:0] ch_key_ff, ch_key_in;
   logic [SW-1:0]        ch_idx_ff, ch_idx_in;
   logic                 lsel_ff, lsel_in;
   logic                 rok_ff, rok_in;
   logic [VTX_W-1:0]     res_vtx_ff, res_vtx_in;
   status_type           res_stat_ff, res_stat_in;
   logic [VTX_W-1:0]     clr_ff, clr_in;
   logic                 rsp_valid_ff;
   logic [VTX_W-1:0]     rsp_vtx_ff;
   status_type           rsp_stat_ff;
   logic                 ld_rsp;

   logic                 hp_we, hp_re;
   logic [SW-1:0]        hp_wa, hp_ra;
   logic [HW-1:0]        hp_wd, hp_rd;
   logic                 ps_we, ps_re;
   logic [VTX_W-1:0]     ps_wa, ps_ra;
   logic [PW-1:0]        ps_wd, ps_rd;

   logic                 acc;
   logic [KEY_EXT_W-1:0] key_ext;
   logic [KEY_WIDTH-1:0] key_in;
   logic [VTX_W-1:0]     hp_rd_vtx;
   logic [KEY_WIDTH-1:0] hp_rd_key;
   logic [CW-1:0]        cm1;
   logic [CXW-1:0]       lidx, ridx, count_x;
   logic [KEY_WIDTH-1:0] best_key;

   // Key is cut (or padded) to KEY_WIDTH bits.
   assign key_ext   = {{(KEY_EXT_W - KEY_IN_W){1'b0}}, req_key};
   assign key_in    = key_ext[KEY_WIDTH-1:0];
   assign hp_rd_vtx = hp_rd[HW-1:KEY_WIDTH];
   assign hp_rd_key = hp_rd[KEY_WIDTH-1:0];
   assign cm1       = count_ff - CW'(1);
   assign count_x   = CXW'(count_ff);
   assign lidx      = (CXW'(s_ff) << 1) + CXW'(1);
   assign ridx      = lidx + CXW'(1);
   assign best_key  = lsel_ff ? ch_key_ff : e_key_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign acc       = req_valid && !req_stall;

   imhdk_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
      .clock   (clock),
      .wr_en   (hp_we),
      .wr_addr (hp_wa),
      .wr_data (hp_wd),
      .rd_en   (hp_re),
      .rd_addr (hp_ra),
      .rd_data (hp_rd)
   );

   imhdk_ram #(.WIDTH(PW), .DEPTH(VERTEX_SLOTS)) u_pos (
      .clock   (clock),
      .wr_en   (ps_we),
      .wr_addr (ps_wa),
      .wr_data (ps_wd),
      .rd_en   (ps_re),
      .rd_addr (ps_ra),
      .rd_data (ps_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
         if (ld_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      up_ff       <= up_in;
      e_vtx_ff    <= e_vtx_in;
      e_key_ff    <= e_key_in;
      ch_vtx_ff   <= ch_vtx_in;
      ch_key_ff   <= ch_key_in;
      ch_idx_ff   <= ch_idx_in;
      lsel_ff     <= lsel_in;
      rok_ff      <= rok_in;
      res_vtx_ff  <= res_vtx_in;
      res_stat_ff <= res_stat_in;
      if (ld_rsp) begin
         rsp_vtx_ff  <= res_vtx_ff;
         rsp_stat_ff <= res_stat_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      s_in        = s_ff;
      up_in       = up_ff;
      e_vtx_in    = e_vtx_ff;
      e_key_in    = e_key_ff;
      ch_vtx_in   = ch_vtx_ff;
      ch_key_in   = ch_key_ff;
      ch_idx_in   = ch_idx_ff;
      lsel_in     = lsel_ff;
      rok_in      = rok_ff;
      res_vtx_in  = res_vtx_ff;
      res_stat_in = res_stat_ff;
      clr_in      = clr_ff;
      ld_rsp      = 1'b0;
      hp_we       = 1'b0;
      hp_wa       = s_ff;
      hp_wd       = {e_vtx_ff, e_key_ff};
      hp_re       = 1'b0;
      hp_ra       = '0;
      ps_we       = 1'b0;
      ps_wa       = e_vtx_ff;
      ps_wd       = {1'b1, s_ff};
      ps_re       = 1'b0;
      ps_ra       = req_vertex;
      unique case (state_ff)
         ST_CLEAR: begin
            ps_we  = 1'b1;
            ps_wa  = clr_ff;
            ps_wd  = '0;
            clr_in = clr_ff + VTX_W'(1);
            if (clr_ff == VTX_W'(VERTEX_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (acc) begin
               e_vtx_in    = req_vertex;
               e_key_in    = key_in;
               res_vtx_in  = '0;
               res_stat_in = STAT_OK;
               if (req_operation == OP_EXTRACT) begin
                  if (count_ff == '0) begin
                     res_stat_in = STAT_EMPTY;
                     state_in    = ST_FIN;
                  end else begin
                     hp_re    = 1'b1;
                     hp_ra    = '0;
                     state_in = ST_X_ROOT;
                  end
               end else begin
                  ps_re    = 1'b1;
                  state_in = ST_POS;
               end
            end
         end
         ST_POS: begin
            if (ps_rd[SW] && (CW'(ps_rd[SW-1:0]) < count_ff)) begin
               s_in     = ps_rd[SW-1:0];
               state_in = ST_UP_RD;
            end else if (count_ff == CW'(CAPACITY)) begin
               res_stat_in = STAT_FULL;
               state_in    = ST_FIN;
            end else begin
               s_in     = count_ff[SW-1:0];
               count_in = count_ff + CW'(1);
               state_in = ST_UP_RD;
            end
         end
         ST_UP_RD: begin
            if (s_ff == '0) begin
               hp_we    = 1'b1;
               ps_we    = 1'b1;
               state_in = ST_FIN;
            end else begin
               up_in    = (s_ff - SW'(1)) >> 1;
               hp_re    = 1'b1;
               hp_ra    = (s_ff - SW'(1)) >> 1;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            hp_we = 1'b1;
            ps_we = 1'b1;
            if (hp_rd_key > e_key_ff) begin
               // parent moves down into the hole
               hp_wd    = hp_rd;
               ps_wa    = hp_rd_vtx;
               s_in     = up_ff;
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_X_ROOT: begin
            res_vtx_in = hp_rd_vtx;
            hp_re      = 1'b1;
            hp_ra      = cm1[SW-1:0];
            state_in   = ST_X_LAST;
         end
         ST_X_LAST: begin
            e_vtx_in = hp_rd_vtx;
            e_key_in = hp_rd_key;
            ps_we    = 1'b1;
            ps_wa    = res_vtx_ff;
            ps_wd    = '0;
            count_in = cm1;
            s_in     = '0;
            state_in = (cm1 == '0) ? ST_FIN : ST_DN_RD;
         end
         ST_DN_RD: begin
            if (lidx < count_x) begin
               hp_re    = 1'b1;
               hp_ra    = lidx[SW-1:0];
               state_in = ST_DN_L;
            end else begin
               hp_we    = 1'b1;
               ps_we    = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_DN_L: begin
            ch_vtx_in = hp_rd_vtx;
            ch_key_in = hp_rd_key;
            ch_idx_in = lidx[SW-1:0];
            lsel_in   = (hp_rd_key < e_key_ff);
            rok_in    = (ridx < count_x);
            hp_re     = (ridx < count_x);
            hp_ra     = ridx[SW-1:0];
            state_in  = ST_DN_R;
         end
         ST_DN_R: begin
            hp_we = 1'b1;
            ps_we = 1'b1;
            if (rok_ff && (hp_rd_key < best_key)) begin
               hp_wd    = hp_rd;
               ps_wa    = hp_rd_vtx;
               s_in     = ch_idx_ff + SW'(1);
               state_in = ST_DN_RD;
            end else if (lsel_ff) begin
               hp_wd    = {ch_vtx_ff, ch_key_ff};
               ps_wa    = ch_vtx_ff;
               s_in     = ch_idx_ff;
               state_in = ST_DN_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ld_rsp   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_vertex_out = rsp_vtx_ff;
   assign rsp_status     = rsp_stat_ff;

   `IMH_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CW'(CAPACITY), "entry count over capacity")
   `IMH_ASSERT_NEXT(a_empty_extract, acc && req_operation && (count_ff == '0), (res_stat_ff == STAT_EMPTY) && (state_ff == ST_FIN), "empty extract not flagged")
   `IMH_ASSERT_SAME(a_count_step, state_ff != ST_CLEAR, (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CW'(1)) || (count_ff == $past(count_ff) - CW'(1)), "entry count jumped")
   `IMH_ASSERT_SAME(a_status_legal, rsp_valid, (rsp_status == STAT_OK) || (rsp_status == STAT_EMPTY) || (rsp_status == STAT_FULL), "bad status code")

endmodule
`default_nettype wire
